### rtl/dmtf_pkg.sv
// Package for the DHCP message-type finder: phase and verdict codes,
// option codes, the magic cookie table and the item structs.
// No dependencies; the RTL modules refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package dmtf_pkg;

    typedef enum logic [2:0] {
        PH_COOKIE = 3'd0,
        PH_CODE   = 3'd1,
        PH_LEN    = 3'd2,
        PH_SKIP   = 3'd3,
        PH_VALUE  = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        V_NONE      = 3'd0,
        V_OFFER     = 3'd1,
        V_ACK       = 3'd2,
        V_NAK       = 3'd3,
        V_OTHER     = 3'd4,
        V_BADCOOKIE = 3'd5
    } verdict_t;

    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_END      = 8'd255;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] TYPE_LEN     = 8'd1;

    localparam logic [7:0] TYPE_OFFER = 8'd2;
    localparam logic [7:0] TYPE_ACK   = 8'd5;
    localparam logic [7:0] TYPE_NAK   = 8'd6;

    localparam logic [7:0] COOKIE_0 = 8'h63;
    localparam logic [7:0] COOKIE_1 = 8'h82;
    localparam logic [7:0] COOKIE_2 = 8'h53;
    localparam logic [7:0] COOKIE_3 = 8'h63;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        verdict_t   verdict;
        logic [7:0] type_value;
    } result_t;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = COOKIE_0;
            2'd1:    b = COOKIE_1;
            2'd2:    b = COOKIE_2;
            default: b = COOKIE_3;
        endcase
        return b;
    endfunction

    function automatic verdict_t classify(input logic [7:0] v);
        verdict_t r;
        case (v)
            TYPE_OFFER: r = V_OFFER;
            TYPE_ACK:   r = V_ACK;
            TYPE_NAK:   r = V_NAK;
            default:    r = V_OTHER;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/dmtf_byte_if.sv
// Request channel carrying one options byte and its last-byte flag.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface dmtf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] opt_byte;
    logic       last_byte;

    modport source (output valid, output opt_byte, output last_byte, input ready);
    modport sink   (input valid, input opt_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/dmtf_result_if.sv
// Result channel carrying the verdict and the message type value.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface dmtf_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [7:0] type_value;

    modport source (output valid, output verdict, output type_value, input ready);
    modport sink   (input valid, input verdict, input type_value, output ready);
endinterface

`default_nettype wire

### rtl/dhcp_message_type_finder.sv
// DHCP message-type finder.
// byte_in takes one options byte per request (cookie first), with
// last_byte set on the final byte of the field. result_out gives one
// request per field: the verdict (none, offer, ack, nak, other type,
// bad cookie) and the message type value, 0 where none was found.
// A byte passes through an input register, is parsed from there,
// and a result enters a two-entry output buffer, whose fill count
// drives result_out.valid.
// Throughput is one byte per cycle unless a last byte waits for buffer
// room; the per-byte state update of the option walker sets that figure.
// While the receiver stalls, results wait in the output buffer; once
// it holds two, a last byte waits in the input register and byte_in
// drops ready. Plain bytes keep flowing until a last byte reaches the
// input register while the buffer is full.
// Reset clears the parser to the cookie check and empties both stages.
// After each last byte the parser returns to the cookie check.
// Depends on dmtf_pkg, the channel interfaces, dmtf_in_stage,
// dmtf_parser and dmtf_result_buf.
`timescale 1ns / 1ps
`default_nettype none

module dhcp_message_type_finder (
    input  wire logic      clk,
    input  wire logic      rst_n,
    dmtf_byte_if.sink      byte_in,
    dmtf_result_if.source  result_out
);

    logic               item_valid;
    dmtf_pkg::in_item_t item;
    logic               item_take;
    logic               buf_ready;
    logic               res_push;
    dmtf_pkg::result_t  res;

    // Drop a plain byte at once; a last byte waits for room in the buffer.
    assign item_take = item_valid && (!item.last_byte || buf_ready);
    assign res_push  = item_valid && item.last_byte;

    dmtf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    dmtf_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (item_take),
        .item  (item),
        .res   (res)
    );

    dmtf_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_push),
        .push_ready (buf_ready),
        .push_data  (res),
        .res_out    (result_out)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.verdict != 3'd6 && result_out.verdict != 3'd7))
    else $error("verdict code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && (result_out.verdict == dmtf_pkg::V_NONE
                              || result_out.verdict == dmtf_pkg::V_BADCOOKIE))
        |-> (result_out.type_value == 8'd0))
    else $error("type value set without a type option");

    assert property (@(posedge clk) disable iff (!rst_n)
        !byte_in.ready |-> (item_valid && item.last_byte && !buf_ready))
    else $error("byte channel stalled without a full result buffer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && buf_ready) |=> result_out.valid)
    else $error("result lost after push");
`endif

endmodule

`default_nettype wire

### rtl/dmtf_parser.sv
// Option walker: cookie check, code/length/value skipping and the
// message type decision, one byte per step. Depends on dmtf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmtf_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire dmtf_pkg::in_item_t item,
    output dmtf_pkg::result_t      res
);

    dmtf_pkg::phase_t   phase_reg, phase_next, step_phase;
    logic [2:0]         cookie_idx_reg, cookie_idx_next, step_cookie_idx;
    logic [7:0]         skip_reg, skip_next, step_skip;
    logic               is_type_reg, is_type_next, step_is_type;
    dmtf_pkg::verdict_t verdict_reg, verdict_next, step_verdict;
    logic [7:0]         type_reg, type_next, step_type;
    logic [7:0]         b;
    logic [2:0]         cookie_inc;
    logic [7:0]         skip_dec;

    assign b          = item.opt_byte;
    assign cookie_inc = cookie_idx_reg + 3'd1;
    assign skip_dec   = skip_reg - 8'd1;

    // Next state: advance by one byte, then fall back to reset after the last one.
    always_comb
    begin
        step_phase      = phase_reg;
        step_cookie_idx = cookie_idx_reg;
        step_skip       = skip_reg;
        step_is_type    = is_type_reg;
        step_verdict    = verdict_reg;
        step_type       = type_reg;
        case (phase_reg)
            dmtf_pkg::PH_COOKIE:
            begin
                if (b != dmtf_pkg::cookie_byte(cookie_idx_reg[1:0]))
                begin
                    step_verdict = dmtf_pkg::V_BADCOOKIE;
                    step_type    = 8'd0;
                    step_phase   = dmtf_pkg::PH_DONE;
                end
                else
                begin
                    step_cookie_idx = cookie_inc;
                    if (cookie_inc[2])
                    begin
                        step_phase = dmtf_pkg::PH_CODE;
                    end
                end
            end
            dmtf_pkg::PH_CODE:
            begin
                if (b == dmtf_pkg::OPT_END)
                begin
                    step_verdict = dmtf_pkg::V_NONE;
                    step_type    = 8'd0;
                    step_phase   = dmtf_pkg::PH_DONE;
                end
                else if (b != dmtf_pkg::OPT_PAD)
                begin
                    step_is_type = (b == dmtf_pkg::OPT_MSG_TYPE);
                    step_phase   = dmtf_pkg::PH_LEN;
                end
            end
            dmtf_pkg::PH_LEN:
            begin
                if (is_type_reg && b == dmtf_pkg::TYPE_LEN)
                begin
                    step_phase = dmtf_pkg::PH_VALUE;
                end
                else if (b == 8'd0)
                begin
                    step_phase = dmtf_pkg::PH_CODE;
                end
                else
                begin
                    step_skip  = b;
                    step_phase = dmtf_pkg::PH_SKIP;
                end
            end
            dmtf_pkg::PH_SKIP:
            begin
                step_skip = skip_dec;
                if (skip_dec == 8'd0)
                begin
                    step_phase = dmtf_pkg::PH_CODE;
                end
            end
            dmtf_pkg::PH_VALUE:
            begin
                step_type    = b;
                step_verdict = dmtf_pkg::classify(b);
                step_phase   = dmtf_pkg::PH_DONE;
            end
            default:
            begin
                step_phase = phase_reg;
            end
        endcase

        if (item.last_byte)
        begin
            phase_next      = dmtf_pkg::PH_COOKIE;
            cookie_idx_next = 3'd0;
            skip_next       = 8'd0;
            is_type_next    = 1'b0;
            verdict_next    = dmtf_pkg::V_NONE;
            type_next       = 8'd0;
        end
        else
        begin
            phase_next      = step_phase;
            cookie_idx_next = step_cookie_idx;
            skip_next       = step_skip;
            is_type_next    = step_is_type;
            verdict_next    = step_verdict;
            type_next       = step_type;
        end
    end

    // Outputs: verdict as it stands once this byte is taken.
    always_comb
    begin
        case (step_phase)
            dmtf_pkg::PH_COOKIE:
            begin
                res.verdict    = dmtf_pkg::V_BADCOOKIE;
                res.type_value = 8'd0;
            end
            dmtf_pkg::PH_DONE:
            begin
                res.verdict    = step_verdict;
                res.type_value = step_type;
            end
            default:
            begin
                res.verdict    = dmtf_pkg::V_NONE;
                res.type_value = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= dmtf_pkg::PH_COOKIE;
            cookie_idx_reg <= 3'd0;
            skip_reg       <= 8'd0;
            is_type_reg    <= 1'b0;
            verdict_reg    <= dmtf_pkg::V_NONE;
            type_reg       <= 8'd0;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            cookie_idx_reg <= cookie_idx_next;
            skip_reg       <= skip_next;
            is_type_reg    <= is_type_next;
            verdict_reg    <= verdict_next;
            type_reg       <= type_next;
        end
    end

endmodule

`default_nettype wire

### rtl/dmtf_result_buf.sv
// Two-entry result buffer; its ready depends only on its own fill count.
// Depends on dmtf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmtf_result_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire dmtf_pkg::result_t push_data,
    dmtf_result_if.source          res_out
);

    logic [1:0]        count_reg, count_next;
    dmtf_pkg::result_t head_reg, head_next;
    dmtf_pkg::result_t tail_reg, tail_next;
    logic              push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign push       = push_valid && push_ready;
    assign pop        = res_out.valid && res_out.ready;

    assign res_out.valid      = (count_reg != 2'd0);
    assign res_out.verdict    = head_reg.verdict;
    assign res_out.type_value = head_reg.type_value;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
            if (count_reg == 2'd0)
            begin
                head_next = push_data;
            end
            else
            begin
                tail_next = push_data;
            end
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
            head_next  = tail_reg;
        end
        else if (push && pop)
        begin
            // Both sides move: the old head leaves, the new request takes its place.
            if (count_reg == 2'd1)
            begin
                head_next = push_data;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

### rtl/dmtf_in_stage.sv
// Input register for the byte channel; holds one request until the
// parser takes it. Depends on dmtf_pkg and dmtf_byte_if.
`timescale 1ns / 1ps
`default_nettype none

module dmtf_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    dmtf_byte_if.sink          byte_in,
    output logic               item_valid,
    output dmtf_pkg::in_item_t item,
    input  wire logic          item_take
);

    logic               valid_reg, valid_next;
    dmtf_pkg::in_item_t item_reg, item_next;
    logic               load;

    assign byte_in.ready = !valid_reg || item_take;
    assign load          = byte_in.valid && byte_in.ready;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load)
        begin
            valid_next          = 1'b1;
            item_next.opt_byte  = byte_in.opt_byte;
            item_next.last_byte = byte_in.last_byte;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

### tb/dhcp_message_type_finder_tb.sv
// Self-checking testbench for dhcp_message_type_finder: options fields go
// in byte by byte, verdicts are predicted per byte and checked on result_out.
// Depends on dmtf_pkg, dmtf_byte_if, dmtf_result_if and the block itself.
`timescale 1ns / 1ps

module dhcp_message_type_finder_tb;

    import dmtf_pkg::*;

    localparam int ITEM_TARGET = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 12;

    // receiver stall styles
    localparam int SINK_FREE   = 0;
    localparam int SINK_COIN   = 1;
    localparam int SINK_STALLS = 2;

    typedef struct packed {
        in_item_t item;
        logic     wait_drain;
    } queued_byte_t;

    logic clk;
    logic rst_n;

    dmtf_byte_if   byte_ch();
    dmtf_result_if result_ch();

    dhcp_message_type_finder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (result_ch)
    );

    queued_byte_t byte_backlog[$];
    result_t      pending_results[$];

    // option walker mirror
    phase_t     walk_phase;
    logic [2:0] cookie_hits;
    logic [7:0] skip_left;
    logic       code_is_msg_type;
    verdict_t   found_verdict;
    logic [7:0] found_type;

    logic req_fired;
    int   gap_left;
    int   burst_left;
    int   sink_mode;
    int   mode_left;
    int   stall_left;

    int queued_bytes;
    int queued_fields;
    int accepted_bytes;
    int checked_results;
    int error_count;
    int verdict_seen[6];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] cookie_at(input logic [1:0] idx);
        logic [7:0] c[4];
        c = '{COOKIE_0, COOKIE_1, COOKIE_2, COOKIE_3};
        return c[idx];
    endfunction

    function automatic verdict_t type_to_verdict(input logic [7:0] v);
        if (v == TYPE_OFFER) return V_OFFER;
        if (v == TYPE_ACK) return V_ACK;
        if (v == TYPE_NAK) return V_NAK;
        return V_OTHER;
    endfunction

    function automatic void clear_walker();
        walk_phase       = PH_COOKIE;
        cookie_hits      = 3'd0;
        skip_left        = 8'd0;
        code_is_msg_type = 1'b0;
        found_verdict    = V_NONE;
        found_type       = 8'd0;
    endfunction

    // Advance the walker by one accepted byte; queue a result on the last one.
    function automatic void walk_byte(input logic [7:0] b, input logic last);
        result_t r;
        case (walk_phase)
            PH_COOKIE:
            begin
                if (b != cookie_at(cookie_hits[1:0]))
                begin
                    found_verdict = V_BADCOOKIE;
                    found_type    = 8'd0;
                    walk_phase    = PH_DONE;
                end
                else
                begin
                    cookie_hits = cookie_hits + 3'd1;
                    if (cookie_hits >= 3'd4) walk_phase = PH_CODE;
                end
            end
            PH_CODE:
            begin
                if (b == OPT_END)
                begin
                    found_verdict = V_NONE;
                    found_type    = 8'd0;
                    walk_phase    = PH_DONE;
                end
                else if (b != OPT_PAD)
                begin
                    code_is_msg_type = (b == OPT_MSG_TYPE);
                    walk_phase       = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (code_is_msg_type && b == TYPE_LEN)
                    walk_phase = PH_VALUE;
                else if (b == 8'd0)
                    walk_phase = PH_CODE;
                else
                begin
                    skip_left  = b;
                    walk_phase = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_left = skip_left - 8'd1;
                if (skip_left == 8'd0) walk_phase = PH_CODE;
            end
            PH_VALUE:
            begin
                found_type    = b;
                found_verdict = type_to_verdict(b);
                walk_phase    = PH_DONE;
            end
            default: ;
        endcase
        if (last)
        begin
            if (walk_phase == PH_COOKIE)
            begin
                r.verdict    = V_BADCOOKIE;
                r.type_value = 8'd0;
            end
            else if (walk_phase == PH_DONE)
            begin
                r.verdict    = found_verdict;
                r.type_value = found_type;
            end
            else
            begin
                r.verdict    = V_NONE;
                r.type_value = 8'd0;
            end
            pending_results.push_back(r);
            clear_walker();
        end
    endfunction

    task automatic push_field(input logic [7:0] bytes[$], input bit drain);
        queued_byte_t q;
        for (int i = 0; i < bytes.size(); i++)
        begin
            q.item.opt_byte  = bytes[i];
            q.item.last_byte = (i == bytes.size() - 1);
            q.wait_drain     = drain && (i == 0);
            byte_backlog.push_back(q);
        end
        queued_bytes  += bytes.size();
        queued_fields += 1;
    endtask

    // Mostly well-formed fields with random options; some noise, bad cookies
    // and truncated fields.
    task automatic add_random_field();
        logic [7:0] fb[$];
        logic [7:0] code;
        int kind;
        int n_opts;
        int len;
        int pick;
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            len = $urandom_range(1, 6);
            repeat (len) fb.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            for (int i = 0; i < 4; i++) fb.push_back(cookie_at(2'(i)));
            if (kind == 1)
            begin
                pick = $urandom_range(0, 3);
                fb[pick] = fb[pick] ^ 8'($urandom_range(1, 255));
            end
            n_opts = $urandom_range(0, 4);
            repeat (n_opts)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 3)
                    fb.push_back(OPT_PAD);
                else if (pick < 9)
                begin
                    fb.push_back(OPT_MSG_TYPE);
                    fb.push_back(TYPE_LEN);
                    case ($urandom_range(0, 3))
                        0: fb.push_back(TYPE_OFFER);
                        1: fb.push_back(TYPE_ACK);
                        2: fb.push_back(TYPE_NAK);
                        default: fb.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                else if (pick == 9)
                begin
                    fb.push_back(OPT_MSG_TYPE);
                    len = $urandom_range(0, 4);
                    if (len == 1) len = 0;
                    fb.push_back(8'(len));
                    repeat (len) fb.push_back(8'($urandom_range(0, 255)));
                end
                else if (pick == 10)
                    fb.push_back(OPT_END);
                else
                begin
                    code = 8'($urandom_range(1, 254));
                    fb.push_back(code);
                    len = ($urandom_range(0, 39) == 0) ? $urandom_range(7, 255)
                                                        : $urandom_range(0, 6);
                    fb.push_back(8'(len));
                    repeat (len) fb.push_back(8'($urandom_range(0, 255)));
                end
            end
            len = $urandom_range(0, 3);
            repeat (len) fb.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0)
            begin
                len = $urandom_range(1, fb.size());
                while (fb.size() > len) void'(fb.pop_back());
            end
        end
        push_field(fb, $urandom_range(0, 24) == 0);
    endtask

    // Driver: hold a request until taken, then advance in bursts with gaps.
    always @(negedge clk)
    begin : drive_bytes
        queued_byte_t nxt;
        if (rst_n)
        begin
            if (!byte_ch.valid || req_fired)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    byte_ch.valid <= 1'b0;
                end
                else if (byte_backlog.size() != 0 &&
                         !(byte_backlog[0].wait_drain && pending_results.size() != 0))
                begin
                    nxt = byte_backlog.pop_front();
                    byte_ch.opt_byte  <= nxt.item.opt_byte;
                    byte_ch.last_byte <= nxt.item.last_byte;
                    byte_ch.valid     <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    byte_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: switch between stall styles every so often.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                sink_mode = $urandom_range(SINK_FREE, SINK_STALLS);
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left = mode_left - 1;
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                result_ch.ready <= 1'b0;
            end
            else if (sink_mode == SINK_FREE)
                result_ch.ready <= 1'b1;
            else if (sink_mode == SINK_COIN)
                result_ch.ready <= 1'($urandom_range(0, 1));
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 20);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted request, check every taken result.
    always @(posedge clk)
    begin : watch_ports
        result_t want;
        if (!rst_n)
            req_fired <= 1'b0;
        else
        begin
            req_fired <= byte_ch.valid && byte_ch.ready;
            if (byte_ch.valid && byte_ch.ready)
            begin
                accepted_bytes += 1;
                walk_byte(byte_ch.opt_byte, byte_ch.last_byte);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count += 1;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected result verdict=%0d type=%0d", $realtime,
                                 result_ch.verdict, result_ch.type_value);
                end
                else
                begin
                    want = pending_results.pop_front();
                    checked_results += 1;
                    if (result_ch.verdict <= 3'd5)
                        verdict_seen[result_ch.verdict] += 1;
                    if (result_ch.verdict !== want.verdict ||
                        result_ch.type_value !== want.type_value)
                    begin
                        error_count += 1;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: result %0d expected verdict=%0d type=%0d, got verdict=%0d type=%0d",
                                     $realtime, checked_results, want.verdict, want.type_value,
                                     result_ch.verdict, result_ch.type_value);
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.opt_byte  = 8'd0;
        byte_ch.last_byte = 1'b0;
        result_ch.ready   = 1'b0;
        gap_left          = 0;
        burst_left        = 0;
        sink_mode         = SINK_FREE;
        mode_left         = 0;
        stall_left        = 0;
        queued_bytes      = 0;
        queued_fields     = 0;
        accepted_bytes    = 0;
        checked_results   = 0;
        error_count       = 0;
        foreach (verdict_seen[i]) verdict_seen[i] = 0;
        clear_walker();

        // short field, then bad last cookie byte
        push_field({8'hFF}, 1'b0);
        push_field({COOKIE_0, COOKIE_1, COOKIE_2, 8'h62}, 1'b0);
        // pad, type option of length 2 skipped, nak, trailing byte ignored
        push_field({COOKIE_0, COOKIE_1, COOKIE_2, COOKIE_3, OPT_PAD,
                    OPT_MSG_TYPE, 8'd2, 8'd0, 8'd0, OPT_MSG_TYPE, TYPE_LEN,
                    TYPE_NAK, 8'hFF}, 1'b0);
        // end option then a type option that must be ignored
        push_field({COOKIE_0, COOKIE_1, COOKIE_2, COOKIE_3, OPT_END,
                    OPT_MSG_TYPE, TYPE_LEN, TYPE_OFFER}, 1'b0);
        // drain once before the random part
        push_field({COOKIE_0, COOKIE_1, COOKIE_2, COOKIE_3, OPT_MSG_TYPE,
                    TYPE_LEN, TYPE_ACK}, 1'b1);
        while (queued_bytes < ITEM_TARGET) add_random_field();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_backlog.size() != 0 || byte_ch.valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d fields; %0d results checked.",
                 accepted_bytes, queued_fields, checked_results);
        $display("Verdicts none/offer/ack/nak/other/bad cookie: %0d/%0d/%0d/%0d/%0d/%0d",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2],
                 verdict_seen[3], verdict_seen[4], verdict_seen[5]);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
